### src/dtia_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dtia_pkg
// Opcodes, register addresses and delay-line stage positions for the
// dual timer interrupt adapter.
// ----------------------------------------------------------------------------
package dtia_pkg;

	typedef enum logic [2:0] {
		OP_TICK  = 3'd0,
		OP_READ  = 3'd1,
		OP_WRITE = 3'd2,
		OP_FLAG  = 3'd3,
		OP_ALARM = 3'd4
	} op_t;

	typedef enum logic [3:0] {
		REG_PRA   = 4'h0,
		REG_PRB   = 4'h1,
		REG_DDRA  = 4'h2,
		REG_DDRB  = 4'h3,
		REG_TALO  = 4'h4,
		REG_TAHI  = 4'h5,
		REG_TBLO  = 4'h6,
		REG_TBHI  = 4'h7,
		REG_TOD0  = 4'h8,
		REG_TOD1  = 4'h9,
		REG_TOD2  = 4'hA,
		REG_TOD3  = 4'hB,
		REG_SDR   = 4'hC,
		REG_ICR   = 4'hD,
		REG_CRA   = 4'hE,
		REG_CRB   = 4'hF
	} reg_addr_t;

	localparam int PIPE_W = 40;

	// Positions of the stages in the timing delay line.
	localparam int S_CA0 = 0;
	localparam int S_CA1 = 1;
	localparam int S_CA2 = 2;
	localparam int S_CA3 = 3;
	localparam int S_CB0 = 4;
	localparam int S_CB1 = 5;
	localparam int S_CB2 = 6;
	localparam int S_CB3 = 7;
	localparam int S_LA0 = 8;
	localparam int S_LA1 = 9;
	localparam int S_LA2 = 10;
	localparam int S_LB0 = 11;
	localparam int S_LB1 = 12;
	localparam int S_LB2 = 13;
	localparam int S_P6L0 = 14;
	localparam int S_P6L1 = 15;
	localparam int S_P7L0 = 16;
	localparam int S_P7L1 = 17;
	localparam int S_IRQ0 = 18;
	localparam int S_IRQ1 = 19;
	localparam int S_OSA = 20;
	localparam int S_OSB = 21;
	localparam int S_RD0 = 22;
	localparam int S_CLR0 = 24;
	localparam int S_CLR1 = 25;
	localparam int S_CLR2 = 26;
	localparam int S_SET0 = 27;
	localparam int S_SET1 = 28;
	localparam int S_ALM0 = 29;
	localparam int S_SI0 = 30;
	localparam int S_SI2 = 32;
	localparam int S_SL0 = 33;
	localparam int S_SL1 = 34;
	localparam int S_SC0 = 35;
	localparam int S_SC1 = 36;
	localparam int S_SC2 = 37;

	localparam logic [PIPE_W-1:0] ONE = {{(PIPE_W-1){1'b0}}, 1'b1};

	// Stages that are loaded directly and never shifted into.
	localparam logic [PIPE_W-1:0] FIRST_STAGES =
		(ONE << S_CA0) | (ONE << S_CB0) | (ONE << S_LA0) | (ONE << S_LB0) |
		(ONE << S_P6L0) | (ONE << S_P7L0) | (ONE << S_IRQ0) | (ONE << S_OSA) |
		(ONE << S_OSB) | (ONE << S_RD0) | (ONE << S_CLR0) | (ONE << S_SET0) |
		(ONE << S_ALM0) | (ONE << S_SI0) | (ONE << S_SL0) | (ONE << S_SC0);

	localparam logic [PIPE_W-1:0] SHIFT_MASK = ~FIRST_STAGES;

endpackage
`default_nettype wire

### src/dual_timer_interrupt_adapter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dual_timer_interrupt_adapter
// Two interval timers, serial shift counter and interrupt control in the
// manner of a classic complex interface adapter.
// ----------------------------------------------------------------------------
// Usage: every input beat is one bus event: a clock tick, a register read,
// a register write, a falling edge on the flag pin or a time-of-day alarm.
// Each input beat produces exactly one output beat carrying the read data
// (zero unless the beat was a read), the port A and B drive values and the
// active-low interrupt line, all showing the state after the event.
// The whole event is evaluated combinationally between the state registers and
// the output register, so the output beat is valid in the cycle after the
// input beat is accepted, and one beat per cycle is sustained while the receiver takes each result.
// in_ready stays high whenever the output register is empty or is being
// emptied in the same cycle, so a stalled receiver holds back new beats only
// while its one pending result is still waiting.
// After reset both counters are zero, both reload latches hold all ones,
// every control, flag, mask, port and direction register is zero, the
// timing delay line is empty and the interrupt line is released.
// ----------------------------------------------------------------------------
module dual_timer_interrupt_adapter
	import dtia_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [2:0] op,
	input  wire logic [3:0] addr,
	input  wire logic [7:0] wdata,
	input  wire logic [7:0] port_a_pins,
	input  wire logic [7:0] port_b_pins,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      rdata,
	output logic [7:0]      port_a_drive,
	output logic [7:0]      port_b_drive,
	output logic            irq_n
);

	// Architectural state.
	logic [15:0]       count_a_q, reload_a_q, count_b_q, reload_b_q;
	logic [PIPE_W-1:0] pipe_q, feed_q;
	logic [7:0]        cra_q, crb_q, flags_q;
	logic [4:0]        mask_q;
	// Timer output bits: index 0 is port B bit 6, index 1 is bit 7.
	logic [1:0]        pb_en_q, pb_lvl_q, pb_tog_q;
	logic [7:0]        pa_latch_q, pb_latch_q, dir_a_q, dir_b_q, sdr_q;
	logic [3:0]        sbits_q;
	logic              irq_line_q;

	// Next-state values.
	logic [15:0]       count_a_d, reload_a_d, count_b_d, reload_b_d;
	logic [PIPE_W-1:0] pipe_d, feed_d;
	logic [7:0]        cra_d, crb_d, flags_d;
	logic [4:0]        mask_d;
	logic [1:0]        pb_en_d, pb_lvl_d, pb_tog_d;
	logic [7:0]        pa_latch_d, pb_latch_d, dir_a_d, dir_b_d, sdr_d;
	logic [3:0]        sbits_d;
	logic              irq_line_d;
	logic [7:0]        rdata_d, drv_a_d, drv_b_d;

	logic accept;
	assign in_ready = !out_valid || out_ready;
	assign accept   = in_valid && in_ready;

	// Current port B drive, used by port B reads.
	logic [7:0] drv_b_cur;
	always_comb begin
		drv_b_cur = pb_latch_q | ~dir_b_q;
		drv_b_cur[7:6] = (drv_b_cur[7:6] & ~pb_en_q) | (pb_lvl_q & pb_en_q);
	end

	always_comb begin
		logic [PIPE_W-1:0] d, f;
		logic              a_out, b_out;
		logic [4:0]        mnew;
		logic [1:0]        e;
		count_a_d  = count_a_q;
		reload_a_d = reload_a_q;
		count_b_d  = count_b_q;
		reload_b_d = reload_b_q;
		pipe_d     = pipe_q;
		feed_d     = feed_q;
		cra_d      = cra_q;
		crb_d      = crb_q;
		flags_d    = flags_q;
		mask_d     = mask_q;
		pb_en_d    = pb_en_q;
		pb_lvl_d   = pb_lvl_q;
		pb_tog_d   = pb_tog_q;
		pa_latch_d = pa_latch_q;
		pb_latch_d = pb_latch_q;
		dir_a_d    = dir_a_q;
		dir_b_d    = dir_b_q;
		sdr_d      = sdr_q;
		sbits_d    = sbits_q;
		irq_line_d = irq_line_q;
		rdata_d    = '0;
		d     = pipe_q;
		f     = feed_q;
		a_out = 1'b0;
		b_out = 1'b0;
		mnew  = mask_q;
		e     = '0;

		case (op)
			OP_TICK: begin
				// Timer A.
				if (d[S_CA3]) count_a_d = count_a_d - 16'd1;
				a_out = (count_a_d == 16'd0) && d[S_CA2];
				if (a_out) begin
					if (d[S_OSA] || f[S_OSA]) begin
						cra_d[0] = 1'b0;
						d[S_CA2] = 1'b0;
						d[S_CA1] = 1'b0;
						d[S_CA0] = 1'b0;
						f[S_CA0] = 1'b0;
					end
					// Cascade: B counts A underflows (CNT is held high).
					if (crb_q[6] && crb_q[0]) d[S_CB1] = 1'b1;
					d[S_LA1] = 1'b1;
				end
				if (d[S_LA1]) begin
					count_a_d = reload_a_q;
					d[S_CA2] = 1'b0;
				end

				// Timer B.
				if (d[S_CB3]) count_b_d = count_b_d - 16'd1;
				b_out = (count_b_d == 16'd0) && d[S_CB2];
				if (b_out) begin
					if (d[S_OSB] || f[S_OSB]) begin
						crb_d[0] = 1'b0;
						d[S_CB2] = 1'b0;
						d[S_CB1] = 1'b0;
						d[S_CB0] = 1'b0;
						f[S_CB0] = 1'b0;
					end
					d[S_LB1] = 1'b1;
				end
				if (d[S_LB1]) begin
					count_b_d = reload_b_q;
					d[S_CB2] = 1'b0;
				end

				// Serial shift counter clocked by timer A underflows.
				if (a_out && cra_q[6]) begin
					if (sbits_d != 4'd0) begin
						f[S_SC0] = ~f[S_SC0];
					end else if (d[S_SL1]) begin
						d[S_SL1] = 1'b0;
						d[S_SL0] = 1'b0;
						f[S_SL0] = 1'b0;
						sbits_d  = 4'd8;
						f[S_SC0] = ~f[S_SC0];
					end
				end
				if (sbits_d != 4'd0) begin
					e = {d[S_SC2], d[S_SC1]};
					if (e == 2'b01) begin
						if (sbits_d == 4'd1) d[S_SI0] = 1'b1;
					end else if (e == 2'b10) begin
						sbits_d = sbits_d - 4'd1;
					end
				end

				// Port B timer outputs.
				if (a_out) begin
					pb_tog_d[0] = ~pb_tog_d[0];
					if (cra_q[1]) begin
						if (!cra_q[2]) begin
							pb_lvl_d[0] = 1'b1;
							d[S_P6L0] = 1'b1;
							d[S_P6L1] = 1'b0;
						end else begin
							pb_lvl_d[0] = ~pb_lvl_d[0];
						end
					end
				end
				if (b_out) begin
					pb_tog_d[1] = ~pb_tog_d[1];
					if (crb_q[1]) begin
						if (!crb_q[2]) begin
							pb_lvl_d[1] = 1'b1;
							d[S_P7L0] = 1'b1;
							d[S_P7L1] = 1'b0;
						end else begin
							pb_lvl_d[1] = ~pb_lvl_d[1];
						end
					end
				end
				if (d[S_P6L1]) pb_lvl_d[0] = 1'b0;
				if (d[S_P7L1]) pb_lvl_d[1] = 1'b0;

				// Interrupt sources.
				if (a_out) flags_d[0] = 1'b1;
				if (b_out && !d[S_RD0]) flags_d[1] = 1'b1;
				if ((a_out && mask_q[0]) || (b_out && mask_q[1])) begin
					d[S_IRQ0] = 1'b1;
					d[S_SET0] = 1'b1;
				end
				if (d[S_ALM0]) begin
					flags_d[2] = 1'b1;
					if (mask_q[2]) begin
						d[S_IRQ0] = 1'b1;
						d[S_SET0] = 1'b1;
					end
				end
				if (d[S_SI2]) begin
					flags_d[3] = 1'b1;
					if (mask_q[3]) begin
						d[S_IRQ0] = 1'b1;
						d[S_SET0] = 1'b1;
					end
				end
				if (d[S_CLR1]) flags_d[7] = 1'b0;
				if (d[S_SET1]) flags_d[7] = 1'b1;
				if (d[S_IRQ1]) irq_line_d = 1'b0;

				feed_d = f;
				pipe_d = ((d << 1) & SHIFT_MASK) | f;
			end

			OP_READ: begin
				case (addr)
					REG_PRA:  rdata_d = (pa_latch_q | ~dir_a_q) & port_a_pins;
					REG_PRB:  rdata_d = drv_b_cur & port_b_pins;
					REG_DDRA: rdata_d = dir_a_q;
					REG_DDRB: rdata_d = dir_b_q;
					REG_TALO: rdata_d = count_a_q[7:0];
					REG_TAHI: rdata_d = count_a_q[15:8];
					REG_TBLO: rdata_d = count_b_q[7:0];
					REG_TBHI: rdata_d = count_b_q[15:8];
					REG_SDR:  rdata_d = sdr_q;
					REG_ICR: begin
						// Reading the flags acknowledges them.
						rdata_d = flags_q;
						irq_line_d = 1'b1;
						pipe_d[S_IRQ0] = 1'b0;
						pipe_d[S_IRQ1] = 1'b0;
						flags_d = flags_q & 8'h80;
						pipe_d[S_CLR0] = 1'b1;
						pipe_d[S_RD0] = 1'b1;
					end
					REG_CRA:  rdata_d = cra_q & 8'hEF;
					REG_CRB:  rdata_d = crb_q & 8'hEF;
					default:  rdata_d = '0;
				endcase
			end

			OP_WRITE: begin
				case (addr)
					REG_PRA:  pa_latch_d = wdata;
					REG_PRB:  pb_latch_d = wdata;
					REG_DDRA: dir_a_d = wdata;
					REG_DDRB: dir_b_d = wdata;
					REG_TALO: begin
						reload_a_d[7:0] = wdata;
						if (pipe_q[S_LA2]) count_a_d[7:0] = wdata;
					end
					REG_TAHI: begin
						reload_a_d[15:8] = wdata;
						if (pipe_q[S_LA2]) count_a_d[15:8] = wdata;
						if (!cra_q[0]) pipe_d[S_LA0] = 1'b1;
					end
					REG_TBLO: begin
						reload_b_d[7:0] = wdata;
						if (pipe_q[S_LB2]) count_b_d[7:0] = wdata;
					end
					REG_TBHI: begin
						reload_b_d[15:8] = wdata;
						if (pipe_q[S_LB2]) count_b_d[15:8] = wdata;
						if (!crb_q[0]) pipe_d[S_LB0] = 1'b1;
					end
					REG_SDR: begin
						sdr_d = wdata;
						pipe_d[S_SL0] = 1'b1;
						feed_d[S_SL0] = 1'b1;
					end
					REG_ICR: begin
						if (wdata[7]) mnew = mask_q | wdata[4:0];
						else mnew = mask_q & ~wdata[4:0];
						mask_d = mnew;
						if (((mnew & flags_q[4:0]) != 5'd0) && irq_line_q) begin
							pipe_d[S_IRQ0] = 1'b1;
							pipe_d[S_SET0] = 1'b1;
						end else if (pipe_q[S_CLR2]) begin
							pipe_d[S_IRQ1] = 1'b0;
							pipe_d[S_SET1] = 1'b0;
						end
					end
					REG_CRA: begin
						if (wdata[0]) begin
							pipe_d[S_CA1] = 1'b1;
							pipe_d[S_CA0] = 1'b1;
							feed_d[S_CA0] = 1'b1;
							if (!cra_q[0]) pb_tog_d[0] = 1'b1;
						end else begin
							pipe_d[S_CA1] = 1'b0;
							pipe_d[S_CA0] = 1'b0;
							feed_d[S_CA0] = 1'b0;
						end
						if (wdata[1]) begin
							pb_en_d[0] = 1'b1;
							if (!wdata[2]) pb_lvl_d[0] = pipe_q[S_P6L1];
							else pb_lvl_d[0] = pb_tog_d[0];
						end else begin
							pb_en_d[0] = 1'b0;
						end
						feed_d[S_OSA] = wdata[3];
						if (wdata[4]) pipe_d[S_LA0] = 1'b1;
						if (wdata[5]) begin
							pipe_d[S_CA1] = 1'b0;
							pipe_d[S_CA0] = 1'b0;
							feed_d[S_CA0] = 1'b0;
						end
						// Changing the serial direction aborts any transfer.
						if (wdata[6] != cra_q[6]) begin
							pipe_d[S_SL0] = 1'b0;
							pipe_d[S_SL1] = 1'b0;
							pipe_d[S_SC0] = 1'b0;
							pipe_d[S_SC1] = 1'b0;
							pipe_d[S_SC2] = 1'b0;
							feed_d[S_SL0] = 1'b0;
							feed_d[S_SC0] = 1'b0;
							sbits_d = 4'd0;
						end
						cra_d = wdata;
					end
					REG_CRB: begin
						if (wdata[0]) begin
							pipe_d[S_CB1] = 1'b1;
							pipe_d[S_CB0] = 1'b1;
							feed_d[S_CB0] = 1'b1;
							if (!crb_q[0]) pb_tog_d[1] = 1'b1;
						end else begin
							pipe_d[S_CB1] = 1'b0;
							pipe_d[S_CB0] = 1'b0;
							feed_d[S_CB0] = 1'b0;
						end
						if (wdata[1]) begin
							pb_en_d[1] = 1'b1;
							if (!wdata[2]) pb_lvl_d[1] = pipe_q[S_P7L1];
							else pb_lvl_d[1] = pb_tog_d[1];
						end else begin
							pb_en_d[1] = 1'b0;
						end
						feed_d[S_OSB] = wdata[3];
						if (wdata[4]) pipe_d[S_LB0] = 1'b1;
						if (wdata[5] || wdata[6]) begin
							pipe_d[S_CB1] = 1'b0;
							pipe_d[S_CB0] = 1'b0;
							feed_d[S_CB0] = 1'b0;
						end
						crb_d = wdata;
					end
					default: ;
				endcase
			end

			OP_FLAG: begin
				flags_d[4] = 1'b1;
				if (mask_q[4]) begin
					irq_line_d = 1'b0;
					flags_d[7] = 1'b1;
				end
			end

			OP_ALARM: pipe_d[S_ALM0] = 1'b1;

			default: ;
		endcase

		drv_a_d = pa_latch_d | ~dir_a_d;
		drv_b_d = pb_latch_d | ~dir_b_d;
		drv_b_d[7:6] = (drv_b_d[7:6] & ~pb_en_d) | (pb_lvl_d & pb_en_d);
	end

	// State registers advance once per accepted beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_a_q  <= '0;
			reload_a_q <= '1;
			count_b_q  <= '0;
			reload_b_q <= '1;
			pipe_q     <= '0;
			feed_q     <= '0;
			cra_q      <= '0;
			crb_q      <= '0;
			flags_q    <= '0;
			mask_q     <= '0;
			pb_en_q    <= '0;
			pb_lvl_q   <= '0;
			pb_tog_q   <= '0;
			pa_latch_q <= '0;
			pb_latch_q <= '0;
			dir_a_q    <= '0;
			dir_b_q    <= '0;
			sdr_q      <= '0;
			sbits_q    <= '0;
			irq_line_q <= 1'b1;
		end else if (accept) begin
			count_a_q  <= count_a_d;
			reload_a_q <= reload_a_d;
			count_b_q  <= count_b_d;
			reload_b_q <= reload_b_d;
			pipe_q     <= pipe_d;
			feed_q     <= feed_d;
			cra_q      <= cra_d;
			crb_q      <= crb_d;
			flags_q    <= flags_d;
			mask_q     <= mask_d;
			pb_en_q    <= pb_en_d;
			pb_lvl_q   <= pb_lvl_d;
			pb_tog_q   <= pb_tog_d;
			pa_latch_q <= pa_latch_d;
			pb_latch_q <= pb_latch_d;
			dir_a_q    <= dir_a_d;
			dir_b_q    <= dir_b_d;
			sdr_q      <= sdr_d;
			sbits_q    <= sbits_d;
			irq_line_q <= irq_line_d;
		end
	end

	// Output register.
	logic out_valid_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	logic [7:0] rdata_q, drv_a_q, drv_b_q;
	logic       irq_n_q;
	always_ff @(posedge clk) begin
		if (accept) begin
			rdata_q <= rdata_d;
			drv_a_q <= drv_a_d;
			drv_b_q <= drv_b_d;
			irq_n_q <= irq_line_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign rdata        = rdata_q;
	assign port_a_drive = drv_a_q;
	assign port_b_drive = drv_b_q;
	assign irq_n        = irq_n_q;

endmodule
`default_nettype wire

### dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the dual timer interrupt adapter. A directed table
// of bus events is followed by random register programming and tick runs.
// Every output beat is checked against an in-bench model of the timers, the
// serial counter and the interrupt logic.
// ----------------------------------------------------------------------------
module tb_top;
	import dtia_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int N_RANDOM = 950;

	// Opcodes with no function; the block must leave its state alone for them.
	localparam logic [2:0] OP_UNUSED_LO = 3'd5;
	localparam logic [2:0] OP_UNUSED_HI = 3'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [2:0] op = OP_TICK;
	logic [3:0] addr = '0;
	logic [7:0] wdata = '0;
	logic [7:0] port_a_pins = '0;
	logic [7:0] port_b_pins = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [7:0] rdata, port_a_drive, port_b_drive;
	logic irq_n;

	dual_timer_interrupt_adapter dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.op(op), .addr(addr), .wdata(wdata),
		.port_a_pins(port_a_pins), .port_b_pins(port_b_pins),
		.out_valid(out_valid), .out_ready(out_ready),
		.rdata(rdata), .port_a_drive(port_a_drive),
		.port_b_drive(port_b_drive), .irq_n(irq_n)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// One bus event as the sender offers it.
	typedef struct packed {
		logic [2:0] op;
		logic [3:0] addr;
		logic [7:0] wdata;
		logic [7:0] pa;
		logic [7:0] pb;
	} bus_event_t;

	// What the block reports after one event.
	typedef struct packed {
		logic [7:0] rdata;
		logic [7:0] pa_drive;
		logic [7:0] pb_drive;
		logic       irq_n;
	} event_result_t;

	// Shadow copy of the adapter state.
	logic [15:0] m_cnt_a, m_lat_a, m_cnt_b, m_lat_b;
	logic [PIPE_W-1:0] m_dly, m_feed;
	logic [7:0] m_cra, m_crb, m_icr, m_imr;
	logic [7:0] m_pb_en, m_pb_lvl, m_pb_tgl;
	logic [7:0] m_pra, m_prb, m_ddra, m_ddrb, m_sdr;
	logic [3:0] m_sbits;
	logic m_irq;

	event_result_t pending_results[$];
	int mismatches = 0;
	int beats_in = 0, beats_out = 0, irq_seen = 0, underflows_seen = 0;
	bit stim_done = 1'b0;
	bit hold_off = 1'b0;

	function automatic logic [PIPE_W-1:0] bitv(input int n);
		return ONE << n;
	endfunction

	function automatic logic [7:0] drive_of_a();
		return m_pra | ~m_ddra;
	endfunction

	function automatic logic [7:0] drive_of_b();
		logic [7:0] base;
		base = m_prb | ~m_ddrb;
		return (base & ~m_pb_en) | (m_pb_lvl & m_pb_en);
	endfunction

	task automatic model_reset();
		m_cnt_a = '0; m_lat_a = 16'hFFFF; m_cnt_b = '0; m_lat_b = 16'hFFFF;
		m_dly = '0; m_feed = '0;
		m_cra = '0; m_crb = '0; m_icr = '0; m_imr = '0;
		m_pb_en = '0; m_pb_lvl = '0; m_pb_tgl = '0;
		m_pra = '0; m_prb = '0; m_ddra = '0; m_ddrb = '0; m_sdr = '0;
		m_sbits = '0; m_irq = 1'b1;
	endtask

	// One bus clock tick of the timers and the interrupt delay line.
	task automatic model_tick();
		logic [PIPE_W-1:0] d, f;
		logic a_out, b_out;
		logic [PIPE_W-1:0] e;
		d = m_dly; f = m_feed;
		if (d[S_CA3]) m_cnt_a = m_cnt_a - 16'd1;
		a_out = (m_cnt_a == 0) && d[S_CA2];
		if (a_out) begin
			if (d[S_OSA] | f[S_OSA]) begin
				m_cra &= 8'hFE;
				d &= ~(bitv(S_CA2) | bitv(S_CA1) | bitv(S_CA0));
				f &= ~bitv(S_CA0);
			end
			if ((m_crb & 8'h61) == 8'h41 || (m_crb & 8'h61) == 8'h61) d |= bitv(S_CB1);
			d |= bitv(S_LA1);
		end
		if (d[S_LA1]) begin
			m_cnt_a = m_lat_a;
			d &= ~bitv(S_CA2);
		end
		if (d[S_CB3]) m_cnt_b = m_cnt_b - 16'd1;
		b_out = (m_cnt_b == 0) && d[S_CB2];
		if (b_out) begin
			if (d[S_OSB] | f[S_OSB]) begin
				m_crb &= 8'hFE;
				d &= ~(bitv(S_CB2) | bitv(S_CB1) | bitv(S_CB0));
				f &= ~bitv(S_CB0);
			end
			d |= bitv(S_LB1);
		end
		if (d[S_LB1]) begin
			m_cnt_b = m_lat_b;
			d &= ~bitv(S_CB2);
		end
		if (a_out && m_cra[6]) begin
			if (m_sbits != 0) begin
				f ^= bitv(S_SC0);
			end else if (d[S_SL1]) begin
				d &= ~(bitv(S_SL1) | bitv(S_SL0));
				f &= ~bitv(S_SL0);
				m_sbits = 4'd8;
				f ^= bitv(S_SC0);
			end
		end
		if (m_sbits != 0) begin
			e = d & (bitv(S_SC2) | bitv(S_SC1));
			if (e == bitv(S_SC1)) begin
				if (m_sbits == 1) d |= bitv(S_SI0);
			end else if (e == bitv(S_SC2)) begin
				m_sbits = m_sbits - 4'd1;
			end
		end
		if (a_out) begin
			m_pb_tgl ^= 8'h40;
			if (m_cra[1]) begin
				if (!m_cra[2]) begin
					m_pb_lvl |= 8'h40;
					d |= bitv(S_P6L0);
					d &= ~bitv(S_P6L1);
				end else begin
					m_pb_lvl ^= 8'h40;
				end
			end
		end
		if (b_out) begin
			m_pb_tgl ^= 8'h80;
			if (m_crb[1]) begin
				if (!m_crb[2]) begin
					m_pb_lvl |= 8'h80;
					d |= bitv(S_P7L0);
					d &= ~bitv(S_P7L1);
				end else begin
					m_pb_lvl ^= 8'h80;
				end
			end
		end
		if (d[S_P6L1]) m_pb_lvl &= 8'hBF;
		if (d[S_P7L1]) m_pb_lvl &= 8'h7F;
		if (a_out) m_icr |= 8'h01;
		if (b_out && !d[S_RD0]) m_icr |= 8'h02;
		if ((a_out && m_imr[0]) || (b_out && m_imr[1])) d |= bitv(S_IRQ0) | bitv(S_SET0);
		if (d[S_ALM0]) begin
			m_icr |= 8'h04;
			if (m_imr[2]) d |= bitv(S_IRQ0) | bitv(S_SET0);
		end
		if (d[S_SI2]) begin
			m_icr |= 8'h08;
			if (m_imr[3]) d |= bitv(S_IRQ0) | bitv(S_SET0);
		end
		if (d[S_CLR1]) m_icr &= 8'h7F;
		if (d[S_SET1]) m_icr |= 8'h80;
		if (d[S_IRQ1]) m_irq = 1'b0;
		if (a_out || b_out) underflows_seen++;
		m_feed = f;
		m_dly = ((d << 1) & SHIFT_MASK) | f;
	endtask

	function automatic logic [7:0] model_read(input logic [3:0] a, input logic [7:0] pa,
			input logic [7:0] pb);
		logic [7:0] r;
		r = '0;
		case (reg_addr_t'(a))
			REG_PRA:  r = drive_of_a() & pa;
			REG_PRB:  r = drive_of_b() & pb;
			REG_DDRA: r = m_ddra;
			REG_DDRB: r = m_ddrb;
			REG_TALO: r = m_cnt_a[7:0];
			REG_TAHI: r = m_cnt_a[15:8];
			REG_TBLO: r = m_cnt_b[7:0];
			REG_TBHI: r = m_cnt_b[15:8];
			REG_SDR:  r = m_sdr;
			REG_ICR: begin
				r = m_icr;
				m_irq = 1'b1;
				m_dly &= ~(bitv(S_IRQ0) | bitv(S_IRQ1));
				m_icr &= 8'h80;
				m_dly |= bitv(S_CLR0) | bitv(S_RD0);
			end
			REG_CRA:  r = m_cra & 8'hEF;
			REG_CRB:  r = m_crb & 8'hEF;
			default:  r = '0;
		endcase
		return r;
	endfunction

	// Control register write common to both timers; pb_bit is 6 for A, 7 for B.
	task automatic model_ctrl(input logic [7:0] v, input logic [7:0] old, input int pb_bit,
			input int c0, input int c1, input int os, input int ld, input int pend,
			input logic [7:0] stop_bits);
		logic [7:0] m;
		m = 8'h01 << pb_bit;
		if (v[0]) begin
			m_dly |= bitv(c1) | bitv(c0);
			m_feed |= bitv(c0);
			if (!old[0]) m_pb_tgl |= m;
		end else begin
			m_dly &= ~(bitv(c1) | bitv(c0));
			m_feed &= ~bitv(c0);
		end
		if (v[1]) begin
			m_pb_en |= m;
			if (!v[2]) begin
				if (m_dly[pend]) m_pb_lvl |= m;
				else m_pb_lvl &= ~m;
			end else begin
				m_pb_lvl = (m_pb_lvl & ~m) | (m_pb_tgl & m);
			end
		end else begin
			m_pb_en &= ~m;
		end
		if (v[3]) m_feed |= bitv(os);
		else m_feed &= ~bitv(os);
		if (v[4]) m_dly |= bitv(ld);
		if ((v & stop_bits) != 0) begin
			m_dly &= ~(bitv(c1) | bitv(c0));
			m_feed &= ~bitv(c0);
		end
	endtask

	task automatic model_write(input logic [3:0] a, input logic [7:0] v);
		case (reg_addr_t'(a))
			REG_PRA:  m_pra = v;
			REG_PRB:  m_prb = v;
			REG_DDRA: m_ddra = v;
			REG_DDRB: m_ddrb = v;
			REG_TALO: begin
				m_lat_a[7:0] = v;
				if (m_dly[S_LA2]) m_cnt_a[7:0] = v;
			end
			REG_TAHI: begin
				m_lat_a[15:8] = v;
				if (m_dly[S_LA2]) m_cnt_a[15:8] = v;
				if (!m_cra[0]) m_dly |= bitv(S_LA0);
			end
			REG_TBLO: begin
				m_lat_b[7:0] = v;
				if (m_dly[S_LB2]) m_cnt_b[7:0] = v;
			end
			REG_TBHI: begin
				m_lat_b[15:8] = v;
				if (m_dly[S_LB2]) m_cnt_b[15:8] = v;
				if (!m_crb[0]) m_dly |= bitv(S_LB0);
			end
			REG_SDR: begin
				m_sdr = v;
				m_dly |= bitv(S_SL0);
				m_feed |= bitv(S_SL0);
			end
			REG_ICR: begin
				if (v[7]) m_imr |= v & 8'h1F;
				else m_imr &= ~(v & 8'h1F);
				if (((m_imr & m_icr & 8'h1F) != 0) && m_irq)
					m_dly |= bitv(S_IRQ0) | bitv(S_SET0);
				else if (m_dly[S_CLR2])
					m_dly &= ~(bitv(S_IRQ1) | bitv(S_SET1));
			end
			REG_CRA: begin
				model_ctrl(v, m_cra, 6, S_CA0, S_CA1, S_OSA, S_LA0, S_P6L1, 8'h20);
				if ((v ^ m_cra) & 8'h40) begin
					m_dly &= ~(bitv(S_SL0) | bitv(S_SL1) | bitv(S_SC0) | bitv(S_SC1)
						| bitv(S_SC2));
					m_feed &= ~(bitv(S_SL0) | bitv(S_SC0));
					m_sbits = '0;
				end
				m_cra = v;
			end
			REG_CRB: begin
				model_ctrl(v, m_crb, 7, S_CB0, S_CB1, S_OSB, S_LB0, S_P7L1, 8'h60);
				m_crb = v;
			end
			default: ;
		endcase
	endtask

	// Advances the shadow state by one event and returns what the block should report.
	task automatic predict_event(input bus_event_t ev, output event_result_t res);
		logic [7:0] r;
		r = '0;
		case (ev.op)
			OP_TICK:  model_tick();
			OP_READ:  r = model_read(ev.addr, ev.pa, ev.pb);
			OP_WRITE: model_write(ev.addr, ev.wdata);
			OP_FLAG: begin
				m_icr |= 8'h10;
				if (m_imr[4]) begin
					m_irq = 1'b0;
					m_icr |= 8'h80;
				end
			end
			OP_ALARM: m_dly |= bitv(S_ALM0);
			default: ;
		endcase
		res.rdata = r;
		res.pa_drive = drive_of_a();
		res.pb_drive = drive_of_b();
		res.irq_n = m_irq;
	endtask

	// Directed table. A check flag marks rows whose expected result is typed in;
	// that value is compared against the model as well, so the model stays honest.
	typedef struct {
		bus_event_t ev;
		bit         fixed;
		event_result_t res;
	} table_row_t;

	table_row_t dir_rows[$];

	function automatic bus_event_t mk(input logic [2:0] o, input logic [3:0] a,
			input logic [7:0] v, input logic [7:0] pa, input logic [7:0] pb);
		bus_event_t e;
		e.op = o; e.addr = a; e.wdata = v; e.pa = pa; e.pb = pb;
		return e;
	endfunction

	task automatic add_row(input bus_event_t e, input bit fx, input logic [7:0] r,
			input logic [7:0] da, input logic [7:0] db, input logic irq);
		table_row_t t;
		t.ev = e; t.fixed = fx;
		t.res.rdata = r; t.res.pa_drive = da; t.res.pb_drive = db; t.res.irq_n = irq;
		dir_rows.push_back(t);
	endtask

	task automatic build_table();
		// Reset values: latches all ones, counters zero, drives all ones.
		add_row(mk(OP_READ, REG_TALO, 0, 8'hFF, 8'hFF), 1, 8'h00, 8'hFF, 8'hFF, 1);
		add_row(mk(OP_READ, REG_PRA, 0, 8'hA5, 8'hFF), 1, 8'hA5, 8'hFF, 8'hFF, 1);
		add_row(mk(OP_READ, REG_PRB, 0, 8'hFF, 8'h00), 1, 8'h00, 8'hFF, 8'hFF, 1);
		add_row(mk(OP_READ, REG_TOD0, 0, 8'hFF, 8'hFF), 1, 8'h00, 8'hFF, 8'hFF, 1);
		add_row(mk(OP_WRITE, REG_DDRA, 8'hFF, 0, 0), 1, 8'h00, 8'h00, 8'hFF, 1);
		add_row(mk(OP_WRITE, REG_PRA, 8'h5A, 0, 0), 1, 8'h00, 8'h5A, 8'hFF, 1);
		add_row(mk(OP_WRITE, REG_DDRB, 8'hFF, 0, 0), 1, 8'h00, 8'h5A, 8'h00, 1);
		add_row(mk(OP_WRITE, REG_PRB, 8'hFF, 0, 0), 0, 0, 0, 0, 0);
		// Short latches, interrupts unmasked for both timers, the alarm, the serial port and the flag pin.
		add_row(mk(OP_WRITE, REG_TALO, 8'h02, 0, 0), 0, 0, 0, 0, 0);
		add_row(mk(OP_WRITE, REG_TAHI, 8'h00, 0, 0), 0, 0, 0, 0, 0);
		add_row(mk(OP_WRITE, REG_TBLO, 8'h01, 0, 0), 0, 0, 0, 0, 0);
		add_row(mk(OP_WRITE, REG_TBHI, 8'h00, 0, 0), 0, 0, 0, 0, 0);
		add_row(mk(OP_WRITE, REG_ICR, 8'h9F, 0, 0), 0, 0, 0, 0, 0);
		// Timer A in toggle mode with serial out, B cascaded one-shot with pulses.
		add_row(mk(OP_WRITE, REG_CRA, 8'h57, 0, 0), 0, 0, 0, 0, 0);
		add_row(mk(OP_WRITE, REG_CRB, 8'h4B, 0, 0), 0, 0, 0, 0, 0);
		add_row(mk(OP_WRITE, REG_SDR, 8'hC3, 0, 0), 0, 0, 0, 0, 0);
		for (int i = 0; i < 6; i++) add_row(mk(OP_TICK, 0, 0, 0, 0), 0, 0, 0, 0, 0);
		add_row(mk(OP_ALARM, 0, 0, 0, 0), 0, 0, 0, 0, 0);
		add_row(mk(OP_FLAG, 0, 0, 0, 0), 0, 0, 0, 0, 0);
		add_row(mk(OP_READ, REG_ICR, 0, 0, 0), 0, 0, 0, 0, 0);
		add_row(mk(OP_UNUSED_HI, REG_CRB, 8'hFF, 0, 0), 0, 0, 0, 0, 0);
		add_row(mk(OP_READ, REG_CRA, 0, 0, 0), 0, 0, 0, 0, 0);
	endtask

	// A random event, biased toward ticks and small timer values so that the
	// counters underflow often and the interrupt path gets exercised.
	function automatic bus_event_t rand_event();
		bus_event_t e;
		int k;
		e.addr = 4'($urandom_range(0, 15));
		e.wdata = 8'($urandom);
		e.pa = 8'($urandom);
		e.pb = 8'($urandom);
		k = $urandom_range(0, 99);
		if (k < 55) e.op = OP_TICK;
		else if (k < 70) e.op = OP_READ;
		else if (k < 92) e.op = OP_WRITE;
		else if (k < 95) e.op = OP_FLAG;
		else if (k < 98) e.op = OP_ALARM;
		else e.op = 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
		// Timer high bytes stay small most of the time so that underflows come.
		if (e.op == OP_WRITE && (e.addr == REG_TAHI || e.addr == REG_TBHI)
				&& $urandom_range(0, 9) != 0)
			e.wdata = 8'h00;
		if (e.op == OP_WRITE && (e.addr == REG_TALO || e.addr == REG_TBLO)
				&& $urandom_range(0, 3) != 0)
			e.wdata = 8'($urandom_range(0, 12));
		return e;
	endfunction

	function automatic int gap_len();
		int k;
		k = $urandom_range(0, 99);
		if (k < 55) return 0;
		if (k < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Offers one beat and waits for it to be taken. Valid stays high across
	// back-to-back beats, so it is only lowered when a gap follows.
	task automatic send_beat(input bus_event_t e, input bit fixed, input event_result_t fres);
		event_result_t res;
		predict_event(e, res);
		if (fixed && res !== fres) begin
			mismatches++;
			if (mismatches <= 10)
				$display("table mismatch op=%0d addr=%h: typed %h, model %h",
					e.op, e.addr, fres, res);
		end
		op <= e.op; addr <= e.addr; wdata <= e.wdata;
		port_a_pins <= e.pa; port_b_pins <= e.pb;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		pending_results.push_back(res);
		beats_in++;
	endtask

	task automatic idle_gap();
		int g;
		g = gap_len();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	// Output side: random ready with one long hold-off while beats keep coming.
	initial begin
		int g;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off) begin
				out_ready <= 1'b0;
			end else begin
				g = gap_len();
				out_ready <= (g == 0);
				if (g > 0) begin
					repeat (g) @(posedge clk);
					out_ready <= 1'b1;
				end
			end
		end
	end

	// The long hold-off counts its own cycles.
	initial begin
		wait (beats_in > 300);
		hold_off = 1'b1;
		repeat (200) @(posedge clk);
		hold_off = 1'b0;
	end

	// Compare each accepted output beat with the oldest prediction.
	always @(posedge clk) begin
		event_result_t got, want;
		if (arst_n && out_valid && out_ready) begin
			got.rdata = rdata; got.pa_drive = port_a_drive;
			got.pb_drive = port_b_drive; got.irq_n = irq_n;
			beats_out++;
			if (!irq_n) irq_seen++;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("output beat with nothing expected: %h", got);
			end else begin
				want = pending_results.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("beat %0d: rdata exp %h got %h,",
							beats_out, want.rdata, got.rdata,
							" pa exp %h got %h, pb exp %h got %h,",
							want.pa_drive, got.pa_drive,
							want.pb_drive, got.pb_drive,
							" irq_n exp %b got %b", want.irq_n, got.irq_n);
				end
			end
		end
	end

	// Watchdog on cycles without any accepted beat.
	initial begin
		int idle;
		idle = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready)) idle = 0;
			else idle++;
			if (idle >= WATCHDOG_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	initial begin
		event_result_t none;
		none = '0;
		model_reset();
		build_table();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_rows[i]) begin
			send_beat(dir_rows[i].ev, dir_rows[i].fixed, dir_rows[i].res);
			idle_gap();
		end
		for (int i = 0; i < N_RANDOM; i++) begin
			send_beat(rand_event(), 1'b0, none);
			idle_gap();
		end
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		$display("Sent %0d bus events and checked %0d output beats.", beats_in, beats_out);
		$display("Timer underflows modeled: %0d, beats with interrupt asserted: %0d.",
			underflows_seen, irq_seen);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

### filelist.f
src/dtia_pkg.sv
src/dual_timer_interrupt_adapter.sv
dv/tb_top.sv
